/* hdl/mlot_pkg.sv */
// Package for the memory lock override table: command codes, transaction and token types.
package mlot_pkg;

  localparam int ADDR_W = 24;
  localparam int BYTE_W = 8;
  localparam int CMD_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_SET    = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_APPEND = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] value;
    logic              lock_flag;
  } req_t;

  typedef struct packed {
    logic              handled;
    logic [BYTE_W-1:0] read_data;
    logic              found;
    logic              mem_write;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_data;
    logic              full_res;
  } rsp_t;

  // Command travelling down the row of cells, gathering its outcome as it goes.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] value;
    logic              lock_flag;
    logic              matched;
    logic              handled;
    logic [BYTE_W-1:0] read_data;
  } token_t;

endpackage

/* hdl/memory_lock_override_table_unit.sv */
// Top level of the memory lock override table: cell row, entry count and response register.
//
// Requests arrive on req_valid/req_ready as one req_t transaction: a bus read
// or write to check against the table, or a table edit (set, remove, clear,
// append unlocked). Each request produces exactly one rsp_t transaction on
// rsp_valid/rsp_ready.
// The table is a row of ENTRIES cells. An accepted request travels down the
// row as a token, one cell per cycle; each cell checks its own entry, edits it
// and, for remove, pulls in its right-hand neighbour so order is kept. The
// entry count only changes once the token leaves the last cell.
// rsp_valid is registered together with the response as the token leaves the last cell.
// The table takes one request at a time, so a new request is taken at the
// earliest in the cycle after the response is taken.
// A stalled receiver holds the response in its register and req_ready stays
// low until it is taken. Reset empties the table (count to zero) and drops
// any token in flight; entry contents are left as they are and never read
// until rewritten.
module memory_lock_override_table_unit #(
  parameter int ENTRIES   = 16,
  parameter int ADDR_BITS = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mlot_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mlot_pkg::rsp_t rsp
);
  import mlot_pkg::*;

  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEEP_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] ADDR_KEEP = {ADDR_W{1'b1}} >> (ADDR_W - KEEP_BITS);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             req_take;
  logic             table_full;
  rsp_t             rsp_next;

  logic                 tok_valid [ENTRIES+1];
  token_t               tok       [ENTRIES+1];
  logic [ADDR_BITS-1:0] ent_addr  [ENTRIES];
  logic [BYTE_W-1:0]    ent_byte  [ENTRIES];
  logic                 ent_locked[ENTRIES];

  token_t last_tok;

  // take one request at a time; hold off until its response is taken
  assign req_ready = !busy;
  assign req_take  = req_valid && req_ready;

  // launch the token straight into the first cell, address cut to ADDR_BITS
  assign tok_valid[0]        = req_take;
  assign tok[0].cmd          = req.cmd;
  assign tok[0].address      = req.address & ADDR_KEEP;
  assign tok[0].value        = req.value;
  assign tok[0].lock_flag    = req.lock_flag;
  assign tok[0].matched      = 1'b0;
  assign tok[0].handled      = 1'b0;
  assign tok[0].read_data    = '0;

  generate
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [ADDR_BITS-1:0] nbr_addr;
      logic [BYTE_W-1:0]    nbr_byte;
      logic                 nbr_locked;

      if (i + 1 < ENTRIES) begin : g_nbr
        assign nbr_addr   = ent_addr[i+1];
        assign nbr_byte   = ent_byte[i+1];
        assign nbr_locked = ent_locked[i+1];
      end else begin : g_end
        // last cell has no neighbour; what it pulls in lies beyond the count
        assign nbr_addr   = '0;
        assign nbr_byte   = '0;
        assign nbr_locked = 1'b0;
      end

      mlot_cell #(
        .IDX       (i),
        .ADDR_BITS (ADDR_BITS),
        .CNT_W     (CNT_W)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .count         (count),
        .tok_in_valid  (tok_valid[i]),
        .tok_in        (tok[i]),
        .nbr_addr      (nbr_addr),
        .nbr_byte      (nbr_byte),
        .nbr_locked    (nbr_locked),
        .tok_out_valid (tok_valid[i+1]),
        .tok_out       (tok[i+1]),
        .ent_addr      (ent_addr[i]),
        .ent_byte      (ent_byte[i]),
        .ent_locked    (ent_locked[i])
      );
    end
  endgenerate

  assign last_tok   = tok[ENTRIES];
  assign table_full = count == CNT_W'(ENTRIES);

  // build the response and the new count as the token leaves the row
  always_comb begin
    rsp_next   = '0;
    count_next = count;
    unique case (last_tok.cmd) inside
      CMD_READ, CMD_WRITE: begin
        rsp_next.handled   = last_tok.handled;
        rsp_next.read_data = last_tok.read_data;
      end
      CMD_SET: begin
        rsp_next.found = last_tok.matched;
        if (!last_tok.matched) begin
          if (table_full) begin
            rsp_next.full_res = 1'b1;
          end else begin
            count_next = count + CNT_W'(1);
          end
        end
        // an unlocked set still goes through to memory, even when dropped
        if (!last_tok.lock_flag) begin
          rsp_next.mem_write = 1'b1;
          rsp_next.mem_addr  = last_tok.address;
          rsp_next.mem_data  = last_tok.value;
        end
      end
      CMD_REMOVE: begin
        rsp_next.found = last_tok.matched;
        if (last_tok.matched) begin
          count_next = count - CNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      CMD_APPEND: begin
        if (last_tok.address != '0) begin
          if (table_full) begin
            rsp_next.full_res = 1'b1;
          end else begin
            count_next = count + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tok_valid[ENTRIES]) begin
      rsp <= rsp_next;
    end
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (tok_valid[ENTRIES]) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (req_take) begin
        busy <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* hdl/mlot_cell.sv */
// One table entry with its stage of the command token chain.
module mlot_cell #(
  parameter int IDX       = 0,
  parameter int ADDR_BITS = 24,
  parameter int CNT_W     = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [CNT_W-1:0]        count,
  input  logic                    tok_in_valid,
  input  mlot_pkg::token_t        tok_in,
  input  logic [ADDR_BITS-1:0]    nbr_addr,
  input  logic [mlot_pkg::BYTE_W-1:0] nbr_byte,
  input  logic                    nbr_locked,
  output logic                    tok_out_valid,
  output mlot_pkg::token_t        tok_out,
  output logic [ADDR_BITS-1:0]    ent_addr,
  output logic [mlot_pkg::BYTE_W-1:0] ent_byte,
  output logic                    ent_locked
);
  import mlot_pkg::*;

  logic [ADDR_BITS-1:0] key;
  logic                 occupied;
  logic                 at_tail;
  logic                 hit;
  logic [ADDR_BITS-1:0] ent_addr_next;
  logic [BYTE_W-1:0]    ent_byte_next;
  logic                 ent_locked_next;
  token_t               tok_next;

  generate
    if (ADDR_BITS <= ADDR_W) begin : g_narrow
      assign key = tok_in.address[ADDR_BITS-1:0];
    end else begin : g_wide
      assign key = {{(ADDR_BITS-ADDR_W){1'b0}}, tok_in.address};
    end
  endgenerate

  assign occupied = CNT_W'(IDX) < count;
  assign at_tail  = CNT_W'(IDX) == count;
  assign hit      = occupied && (ent_addr == key);

  always_comb begin
    ent_addr_next   = ent_addr;
    ent_byte_next   = ent_byte;
    ent_locked_next = ent_locked;
    tok_next        = tok_in;
    if (tok_in_valid) begin
      unique case (tok_in.cmd) inside
        CMD_READ, CMD_WRITE: begin
          if (hit && ent_locked) begin
            tok_next.handled = 1'b1;
            if (tok_in.cmd == CMD_READ) begin
              tok_next.read_data = ent_byte;
            end
          end
        end
        CMD_SET: begin
          if (hit && !tok_in.matched) begin
            ent_byte_next    = tok_in.value;
            ent_locked_next  = tok_in.lock_flag;
            tok_next.matched = 1'b1;
          end else if (at_tail && !tok_in.matched) begin
            ent_addr_next   = key;
            ent_byte_next   = tok_in.value;
            ent_locked_next = tok_in.lock_flag;
          end
        end
        CMD_REMOVE: begin
          // close the gap: every entry from the first match on takes its neighbour
          if ((tok_in.matched && occupied) || (hit && !tok_in.matched)) begin
            ent_addr_next    = nbr_addr;
            ent_byte_next    = nbr_byte;
            ent_locked_next  = nbr_locked;
            tok_next.matched = 1'b1;
          end
        end
        CMD_APPEND: begin
          if (at_tail && (key != '0)) begin
            ent_addr_next   = key;
            ent_byte_next   = '0;
            ent_locked_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent_addr   <= ent_addr_next;
    ent_byte   <= ent_byte_next;
    ent_locked <= ent_locked_next;
    tok_out    <= tok_next;
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

endmodule
